// File: hw/rtl/kvt_pkg.sv
// Shared types and constants for the key/value table.
// No dependencies; imported by kvt_mem and key_value_table_top.
package kvt_pkg;

  // Table geometry
  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned OUTCNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } kvt_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_NEW     = 3'd0,
    STAT_UPDATED = 3'd1,
    STAT_HIT     = 3'd2,
    STAT_MISS    = 3'd3,
    STAT_REMOVED = 3'd4,
    STAT_FULL    = 3'd5
  } kvt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } kvt_state_e;

  // Write port of the slot store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kvt_wr_t;

endpackage

// File: hw/rtl/kvt_mem.sv
// Slot store: key and value arrays, one write port and one registered read port.
// Depends on kvt_pkg.
module kvt_mem (
  input  logic                     clk_i,
  input  kvt_pkg::kvt_wr_t         wr_i,
  input  logic [kvt_pkg::IDX_W-1:0] rd_idx_i,
  output logic [kvt_pkg::KEY_W-1:0] rd_key_o,
  output logic [kvt_pkg::VAL_W-1:0] rd_value_o
);
  import kvt_pkg::*;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.idx] <= wr_i.key;
      val_mem[wr_i.idx] <= wr_i.value;
    end
  end

  // Registered read of the slot under scan
  always_ff @(posedge clk_i) begin
    rd_key_o   <= key_mem[rd_idx_i];
    rd_value_o <= val_mem[rd_idx_i];
  end

endmodule

// File: hw/rtl/key_value_table_top.sv
// Key/value table of ENTRIES slots with insert, lookup and remove commands.
// Depends on kvt_pkg and kvt_mem.
//
// A single key comparator walks the slot store one slot per cycle behind a
// registered read, stopping at the first matching valid slot; a finish step
// then commits the slot write and loads the result register, waiting while
// the previous result is still unaccepted. A miss or an insert of a new key
// always walks all ENTRIES slots. The input is ready only while no command
// is in flight; the result register lets the next command start while the
// previous result waits for its beat. An insert of a new key into a full
// table is dropped and reported with status full.
module key_value_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]   cmd_i,
  input  logic signed [kvt_pkg::KEY_W-1:0] key_i,
  input  logic [kvt_pkg::VAL_W-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [kvt_pkg::VAL_W-1:0]   value_out_o,
  output logic [kvt_pkg::STAT_W-1:0]  status_o,
  output logic [kvt_pkg::OUTCNT_W-1:0] entry_count_o
);
  import kvt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  kvt_state_e       state_q, state_d;
  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0] cnt_q;

  // Command registers
  kvt_cmd_e         cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  // Scan pipeline
  logic [IDX_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;
  logic             hit_now, cmp_last;

  // Scan results
  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [VAL_W-1:0] hit_val_q;

  // Result register
  logic              out_vld_q;
  logic              found_q;
  logic [VAL_W-1:0]  vout_q;
  kvt_status_e       status_q;

  // Finish stage
  kvt_wr_t          wr;
  logic             in_fire, finish_fire;
  logic             set_vld, clr_vld;
  logic             found_d;
  logic [VAL_W-1:0] vout_d;
  kvt_status_e      status_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Single shared key comparator
  assign hit_now  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_key == key_q);
  assign cmp_last = cmp_vld_q && (cmp_idx_q == LAST_IDX);

  kvt_mem u_mem (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_idx_i   (rd_idx_q),
    .rd_key_o   (rd_key),
    .rd_value_o (rd_value)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    finish_fire = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (hit_now || cmp_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the result register is free
        if (!out_vld_q || out_ready_i) begin
          finish_fire = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Capture the command beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= kvt_cmd_e'(cmd_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Advance the scan and record hit and first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else if (in_fire) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else if (state_q == S_SCAN) begin
      cmp_vld_q <= 1'b1;
      cmp_idx_q <= rd_idx_q;
      if (rd_idx_q != LAST_IDX) rd_idx_q <= rd_idx_q + IDX_W'(1);
      if (hit_now) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end
      if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && hit_now) hit_val_q <= rd_value;
  end

  // Decide the result and the slot update
  always_comb begin
    found_d   = hit_q;
    vout_d    = '0;
    status_d  = STAT_MISS;
    set_vld   = 1'b0;
    clr_vld   = 1'b0;
    wr.en     = 1'b0;
    wr.idx    = hit_idx_q;
    wr.key    = key_q;
    wr.value  = value_q;
    case (cmd_q)
      CMD_INSERT: begin
        if (hit_q) begin
          status_d = STAT_UPDATED;
          wr.en    = finish_fire;
        end else if (free_q) begin
          status_d = STAT_NEW;
          wr.en    = finish_fire;
          wr.idx   = free_idx_q;
          set_vld  = 1'b1;
        end else begin
          status_d = STAT_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (hit_q) begin
          status_d = STAT_HIT;
          vout_d   = hit_val_q;
        end
      end
      CMD_REMOVE: begin
        if (hit_q) begin
          status_d = STAT_REMOVED;
          clr_vld  = 1'b1;
        end
      end
      default: found_d = 1'b0;
    endcase
  end

  // Commit valid bits and the live count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else if (finish_fire) begin
      if (set_vld) begin
        valid_q[free_idx_q] <= 1'b1;
        cnt_q               <= cnt_q + CNT_W'(1);
      end
      if (clr_vld) begin
        valid_q[hit_idx_q] <= 1'b0;
        cnt_q              <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Result register: load on finish, drop on the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      found_q  <= found_d;
      vout_q   <= vout_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign status_o      = status_q;
  assign entry_count_o = OUTCNT_W'(cnt_q);

  // Live count always equals the number of valid slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(cnt_q))
    else $error("live count does not match valid slots");

  // Count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= ENTRIES)
    else $error("live count above table size");

  // A hit during the scan ends it at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && hit_now) |=> (state_q == S_FINISH))
    else $error("scan continued past a hit");

  // A result appears only from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_FINISH))
    else $error("result valid without a finished command");

endmodule
